// ===== hdl/gpv_pkg.sv =====
// Package for the guide pixel validator: item types, codes, float constants
// and the single-precision multiply/add helpers used by the back end.
// No dependencies.
`timescale 1ns / 1ps

package gpv_pkg;

    localparam int COMP_W = 32;
    localparam int NCOMP  = 4;

    localparam logic [3:0] KIND_ROUGHNESS = 4'd1;
    localparam logic [3:0] KIND_DENOISE   = 4'd2;
    localparam logic [3:0] KIND_REACTIVE  = 4'd3;
    localparam logic [3:0] KIND_DEPTH     = 4'd0;
    localparam logic [3:0] KIND_HIT_DIST  = 4'd4;
    localparam logic [3:0] KIND_MOTION    = 4'd5;
    localparam logic [3:0] KIND_NORMAL    = 4'd6;
    localparam logic [3:0] KIND_DIFF_ALB  = 4'd7;
    localparam logic [3:0] KIND_SPEC_ALB  = 4'd8;
    localparam logic [3:0] KIND_OVERLAY   = 4'd9;

    localparam logic [1:0] REG_GUIDE_KIND = 2'd0;
    localparam logic [1:0] REG_COMP_COUNT = 2'd1;

    localparam logic [2:0] CLS_VALID     = 3'd0;
    localparam logic [2:0] CLS_OOR       = 3'd1;
    localparam logic [2:0] CLS_INF       = 3'd2;
    localparam logic [2:0] CLS_SENTINEL  = 3'd3;
    localparam logic [2:0] CLS_UNEXP_NAN = 3'd4;

    localparam logic [31:0] F_HALF  = 32'h3F00_0000;
    localparam logic [31:0] F_ONE   = 32'h3F80_0000;
    localparam logic [31:0] F_EIGHT = 32'h4100_0000;
    localparam logic [31:0] F_255   = 32'h437F_0000;
    localparam logic [31:0] F_0P99  = 32'h3F7D_70A4;
    localparam logic [31:0] F_1P01  = 32'h3F81_47AE;

    typedef struct packed {
        logic                         first;
        logic [3:0]                   kind;
        logic [2:0]                   count;
        logic                         err;
        logic                         has_inf;
        logic                         has_nan;
        logic                         nan_ok;
        logic [NCOMP-1:0][COMP_W-1:0] comp;
    } gpv_item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQ_MUL,
        BK_SQ_ADD,
        BK_CHECK,
        BK_PRE_MUL,
        BK_PRE_ADD,
        BK_SCALE,
        BK_ROUND,
        BK_EMIT
    } bk_state_t;

    function automatic logic [2:0] want_count(input logic [3:0] kind);
        logic [2:0] w;
        if (kind <= KIND_HIT_DIST)      w = 3'd1;
        else if (kind == KIND_MOTION)   w = 3'd2;
        else if (kind <= KIND_SPEC_ALB) w = 3'd3;
        else if (kind == KIND_OVERLAY)  w = 3'd4;
        else                            w = 3'd0;
        return w;
    endfunction

    // Normalize, round to nearest even and pack; value = m * 2^(e - 176)
    function automatic logic [31:0] round_pack(input logic sgn,
                                               input logic signed [11:0] e_in,
                                               input logic [49:0] m_in);
        logic [49:0]        m;
        logic [49:0]        mask;
        logic signed [11:0] e;
        logic [5:0]         lz;
        logic [5:0]         sh;
        logic               found;
        logic               sticky;
        logic               guard;
        logic [24:0]        mant;
        m      = m_in;
        e      = e_in;
        lz     = 6'd0;
        found  = 1'b0;
        sticky = 1'b0;
        for (int i = 49; i >= 0; i--)
        begin
            if (!found)
            begin
                if (m_in[i]) found = 1'b1;
                else         lz = lz + 6'd1;
            end
        end
        if (m_in == 50'd0) return {sgn, 31'd0};
        m = m << lz;
        e = e - $signed({6'd0, lz});
        if (e < 12'sd1)
        begin
            if (e < -12'sd48)
            begin
                sticky = |m;
                m      = 50'd0;
            end
            else
            begin
                sh     = 6'(12'sd1 - e);
                mask   = (50'd1 << sh) - 50'd1;
                sticky = |(m & mask);
                m      = m >> sh;
            end
            e = 12'sd1;
        end
        mant   = {1'b0, m[49:26]};
        guard  = m[25];
        sticky = sticky | (|m[24:0]);
        if (guard && (sticky || mant[0])) mant = mant + 25'd1;
        if (mant[24])
        begin
            mant = mant >> 1;
            e    = e + 12'sd1;
        end
        if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
        return {sgn, (mant[23] ? 8'(e) : 8'd0), mant[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sgn;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic signed [11:0] e;
        sgn = a[31] ^ b[31];
        if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = ma * mb;
        e  = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
           + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd126;
        return round_pack(sgn, e, {p, 2'b00});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic        a_big;
        logic [7:0]  e_big;
        logic [7:0]  d;
        logic        s_big;
        logic [49:0] m_big;
        logic [49:0] m_sml;
        logic [49:0] mask;
        logic        sticky;
        logic [49:0] sum;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma    = {a[30:23] != 8'd0, a[22:0]};
        mb    = {b[30:23] != 8'd0, b[22:0]};
        a_big = (ea > eb) || (ea == eb && ma >= mb);
        e_big = a_big ? ea : eb;
        d     = a_big ? (ea - eb) : (eb - ea);
        s_big = a_big ? a[31] : b[31];
        m_big = {1'b0, (a_big ? ma : mb), 25'd0};
        m_sml = {1'b0, (a_big ? mb : ma), 25'd0};
        if (d >= 8'd50)
        begin
            sticky = |m_sml;
            m_sml  = 50'd0;
        end
        else
        begin
            mask   = (50'd1 << d[5:0]) - 50'd1;
            sticky = |(m_sml & mask);
            m_sml  = m_sml >> d[5:0];
        end
        m_sml = {m_sml[49:1], m_sml[0] | sticky};
        if (a[31] == b[31]) sum = m_big + m_sml;
        else                sum = m_big - m_sml;
        if (sum == 50'd0) return {a[31] & b[31], 31'd0};
        return round_pack(s_big, $signed({4'd0, e_big}) + 12'sd1, sum);
    endfunction

    localparam logic [31:0] NRM_LO = fp_mul(F_0P99, F_0P99);
    localparam logic [31:0] NRM_HI = fp_mul(F_1P01, F_1P01);

    function automatic logic unit_out(input logic [31:0] v);
        return (v[31] && v[30:0] != 31'd0) || (!v[31] && v > F_ONE);
    endfunction

    function automatic logic is_neg(input logic [31:0] v);
        return v[31] && v[30:0] != 31'd0;
    endfunction

endpackage

// ===== hdl/gpv_front.sv =====
// Front end: configuration registers and input classification.
// Depends on gpv_pkg.
`timescale 1ns / 1ps

module gpv_front
    import gpv_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [3:0]                    cfg_data,
    input  logic                          s_tvalid,
    input  logic [NCOMP*COMP_W-1:0]       s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_ready,
    output logic                          q_push,
    output gpv_item_t                     q_item
);

    logic [3:0] kind_reg;
    logic [2:0] count_reg;
    logic [2:0] want;
    logic       has_inf;
    logic       has_nan;
    logic       ex_ones;
    logic       frac_nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_DEPTH;
            count_reg <= 3'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_GUIDE_KIND) kind_reg <= cfg_data;
            else if (cfg_index == REG_COMP_COUNT) count_reg <= cfg_data[2:0];
        end
    end

    always_comb
    begin
        has_inf = 1'b0;
        has_nan = 1'b0;
        ex_ones = 1'b0;
        frac_nz = 1'b0;
        for (int i = 0; i < NCOMP; i++)
        begin
            ex_ones = s_tdata[i*COMP_W+23 +: 8] == 8'hFF;
            frac_nz = s_tdata[i*COMP_W +: 23] != 23'd0;
            if (3'(i) < count_reg)
            begin
                if (ex_ones && frac_nz)  has_nan = 1'b1;
                if (ex_ones && !frac_nz) has_inf = 1'b1;
            end
        end
    end

    assign want = want_count(kind_reg);

    always_comb
    begin
        q_item.first   = s_tuser;
        q_item.kind    = kind_reg;
        q_item.count   = count_reg;
        q_item.err     = (want == 3'd0) || (want != count_reg);
        q_item.has_inf = has_inf;
        q_item.has_nan = has_nan;
        q_item.nan_ok  = kind_reg == KIND_DEPTH || kind_reg == KIND_ROUGHNESS ||
                         kind_reg == KIND_HIT_DIST || kind_reg == KIND_NORMAL;
        q_item.comp    = s_tdata;
    end

    assign q_push = s_tvalid && q_ready;

endmodule

// ===== hdl/gpv_queue.sv =====
// Two-entry queue of classified pixels between front and back.
// Depends on gpv_pkg.
`timescale 1ns / 1ps

module gpv_queue
    import gpv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gpv_item_t push_item,
    output logic      ready,
    input  logic      pop,
    output logic      head_valid,
    output gpv_item_t head_item
);

    gpv_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      fill_reg <= fill_reg + 2'd1;
            else if (pop && !push) fill_reg <= fill_reg - 2'd1;
        end
    end

    assign ready      = fill_reg != 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_item  = mem[rd_ptr_reg];

endmodule

// ===== hdl/gpv_back.sv =====
// Back end: float sequencer for range checks and debug colour, counters,
// output register. Depends on gpv_pkg.
`timescale 1ns / 1ps

module gpv_back
    import gpv_pkg::*;
#(
    parameter int COUNT_WIDTH = 26
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  gpv_item_t                q_head,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0][7:0]          out_rgb,
    output logic [2:0]               out_cls,
    output logic                     out_err,
    output logic [4:0][COUNT_WIDTH-1:0] out_cnt
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    bk_state_t                    state_reg, state_next;
    gpv_item_t                    item_reg, item_next;
    logic [1:0]                   k_reg, k_next;
    logic [31:0]                  acc_reg, acc_next;
    logic [31:0]                  tmp_reg, tmp_next;
    logic                         oor_reg, oor_next;
    logic [2:0][7:0]              rgb_reg, rgb_next;
    logic [2:0]                   cls_reg, cls_next;
    logic                         err_reg, err_next;
    logic                         ov_reg, ov_next;
    logic [2:0][7:0]              orgb_reg, orgb_next;
    logic [2:0]                   ocls_reg, ocls_next;
    logic                         oerr_reg, oerr_next;
    logic [4:0][COUNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [4:0][COUNT_WIDTH-1:0]  base;
    logic [4:0]                   bump;
    logic                         pre_kind;
    logic [31:0]                  t_sum;
    logic [31:0]                  clamped;
    logic [7:0]                   t_sh;
    logic [23:0]                  t_int;

    function automatic logic [31:0] chan(input gpv_item_t it, input logic [1:0] k);
        logic [31:0] c;
        case (k)
            2'd0:    c = it.comp[0];
            2'd1:    c = (it.count > 3'd1) ? it.comp[1] : it.comp[0];
            default: c = (it.count > 3'd2) ? it.comp[2] : it.comp[0];
        endcase
        return c;
    endfunction

    function automatic logic simple_oor(input gpv_item_t it);
        logic o;
        o = 1'b0;
        if (it.kind <= KIND_REACTIVE)      o = unit_out(it.comp[0]);
        else if (it.kind == KIND_HIT_DIST) o = is_neg(it.comp[0]);
        else if (it.kind >= KIND_DIFF_ALB)
        begin
            for (int i = 0; i < NCOMP; i++)
                if (3'(i) < it.count) o = o | unit_out(it.comp[i]);
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        tmp_reg  <= tmp_next;
        oor_reg  <= oor_next;
        rgb_reg  <= rgb_next;
        cls_reg  <= cls_next;
        err_reg  <= err_next;
        orgb_reg <= orgb_next;
        ocls_reg <= ocls_next;
        oerr_reg <= oerr_next;
    end

    assign pre_kind = item_reg.kind == KIND_MOTION || item_reg.kind == KIND_NORMAL;
    assign clamped  = is_neg(tmp_reg) ? 32'd0 : (unit_out(tmp_reg) ? F_ONE : tmp_reg);
    assign t_sum    = fp_add(tmp_reg, F_HALF);
    assign t_sh     = 8'd150 - t_sum[30:23];
    assign t_int    = {1'b1, t_sum[22:0]} >> t_sh[4:0];

    always_comb
    begin
        bump = 5'd0;
        base = item_reg.first ? '0 : cnt_reg;
        if (!err_reg)
        begin
            unique case (cls_reg)
                CLS_VALID:     bump[0] = 1'b1;
                CLS_OOR:       bump[1:0] = 2'b11;
                CLS_INF:       bump[2] = 1'b1;
                CLS_SENTINEL:  bump[3] = 1'b1;
                CLS_UNEXP_NAN: bump[4] = 1'b1;
                default:       bump = 5'd0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        tmp_next   = tmp_reg;
        oor_next   = oor_reg;
        rgb_next   = rgb_reg;
        cls_next   = cls_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !out_ready;
        orgb_next  = orgb_reg;
        ocls_next  = ocls_reg;
        oerr_next  = oerr_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    k_next    = 2'd0;
                    oor_next  = 1'b0;
                    err_next  = q_head.err;
                    cls_next  = CLS_VALID;
                    if (q_head.err)
                    begin
                        rgb_next   = '0;
                        state_next = BK_EMIT;
                    end
                    else if (q_head.has_inf)
                    begin
                        rgb_next   = {8'd0, 8'd255, 8'd255};
                        cls_next   = CLS_INF;
                        state_next = BK_EMIT;
                    end
                    else if (q_head.has_nan)
                    begin
                        rgb_next   = {8'd255, 8'd0, 8'd255};
                        cls_next   = q_head.nan_ok ? CLS_SENTINEL : CLS_UNEXP_NAN;
                        state_next = BK_EMIT;
                    end
                    else
                    begin
                        oor_next = simple_oor(q_head);
                        if (q_head.kind == KIND_NORMAL)      state_next = BK_SQ_MUL;
                        else if (q_head.kind == KIND_MOTION) state_next = BK_PRE_MUL;
                        else
                        begin
                            tmp_next   = chan(q_head, 2'd0);
                            state_next = BK_SCALE;
                        end
                    end
                end
            end
            BK_SQ_MUL:
            begin
                tmp_next   = fp_mul(item_reg.comp[k_reg], item_reg.comp[k_reg]);
                state_next = BK_SQ_ADD;
            end
            BK_SQ_ADD:
            begin
                acc_next = (k_reg == 2'd0) ? tmp_reg : fp_add(acc_reg, tmp_reg);
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = BK_CHECK;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = BK_SQ_MUL;
                end
            end
            BK_CHECK:
            begin
                oor_next   = acc_reg < NRM_LO || acc_reg > NRM_HI;
                state_next = BK_PRE_MUL;
            end
            BK_PRE_MUL:
            begin
                if (item_reg.kind == KIND_MOTION && k_reg == 2'd2)
                begin
                    tmp_next   = F_HALF;
                    state_next = BK_SCALE;
                end
                else
                begin
                    tmp_next   = fp_mul(chan(item_reg, k_reg),
                                        (item_reg.kind == KIND_NORMAL) ? F_HALF : F_EIGHT);
                    state_next = BK_PRE_ADD;
                end
            end
            BK_PRE_ADD:
            begin
                tmp_next   = fp_add(tmp_reg, F_HALF);
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                tmp_next   = fp_mul(clamped, F_255);
                state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                rgb_next[k_reg] = (t_sum[30:23] < 8'd127) ? 8'd0 : t_int[7:0];
                if (k_reg == 2'd2)
                begin
                    cls_next   = oor_reg ? CLS_OOR : CLS_VALID;
                    state_next = BK_EMIT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    if (pre_kind) state_next = BK_PRE_MUL;
                    else
                    begin
                        tmp_next   = chan(item_reg, k_reg + 2'd1);
                        state_next = BK_SCALE;
                    end
                end
            end
            BK_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    for (int i = 0; i < 5; i++)
                        cnt_next[i] = (bump[i] && base[i] != CNT_MAX) ?
                                      base[i] + 1'b1 : base[i];
                    ov_next    = 1'b1;
                    orgb_next  = rgb_reg;
                    ocls_next  = cls_reg;
                    oerr_next  = err_reg;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_rgb   = orgb_reg;
    assign out_cls   = ocls_reg;
    assign out_err   = oerr_reg;
    assign out_cnt   = cnt_reg;

endmodule

// ===== hdl/guide_pixel_validator.sv =====
// Top level of the guide pixel validator: front, queue and back.
// Depends on gpv_pkg, gpv_front, gpv_queue, gpv_back.
//
//   port group  dir  transaction
//   cfg_*       in   register write: index, data
//   s_*         in   one guide pixel
//   m_*         out  colour, class, error, counters
//
// Path per pixel in the back sequencer: plane errors, infinite or NaN pixels go
// straight to emit; other kinds scale and round each channel, motion and normals
// first pass their channels through a multiply and an add, and normals before that square and sum the components.
// Reset clears configuration to depth with one component and all counters.
// The front keeps accepting into a two-entry queue while the back or output
// stalls, until the queue is full.
`timescale 1ns / 1ps

module guide_pixel_validator
    import gpv_pkg::*;
#(
    parameter  int COUNT_WIDTH = 26,
    localparam int DATA_W      = ((24 + 5 * COUNT_WIDTH + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [3:0]                cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [NCOMP*COMP_W-1:0]   s_tdata,  // comp0, comp1, comp2, comp3
    input  logic                      s_tuser,  // first_pixel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_W-1:0]         m_tdata,  // red, green, blue, valid_count,
                                                // out_of_range_count, infinite_count,
                                                // sentinel_count, unexpected_nan_count
    output logic [3:0]                m_tuser   // pixel_class, plane_error
);

    localparam int PAY_W = 24 + 5 * COUNT_WIDTH;

    logic                        q_push;
    logic                        q_ready;
    logic                        q_pop;
    logic                        q_valid;
    gpv_item_t                   q_in;
    gpv_item_t                   q_head;
    logic [2:0][7:0]             rgb;
    logic [2:0]                  cls;
    logic                        err;
    logic [4:0][COUNT_WIDTH-1:0] cnt;

    gpv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    gpv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    gpv_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (rgb),
        .out_cls   (cls),
        .out_err   (err),
        .out_cnt   (cnt)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign m_tdata   = DATA_W'({cnt, rgb[2], rgb[1], rgb[0]});
    assign m_tuser   = {err, cls};

endmodule

// ===== test/guide_pixel_validator_tb.sv =====
// Testbench for guide_pixel_validator: streams directed and random guide pixels through
// fixed and random register settings and checks every result against a bit-exact float predictor.
// Depends on gpv_pkg and the guide_pixel_validator RTL.
`timescale 1ns / 1ps

module guide_pixel_validator_tb;
    import gpv_pkg::*;

    localparam int  CW          = 26;
    localparam int  DW          = ((24 + 5 * CW + 7) / 8) * 8;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [1:0] REG_SPARE_A   = 2'd2;
    localparam logic [1:0] REG_SPARE_B   = 2'd3;
    localparam logic [31:0] F_INF  = 32'h7F80_0000;
    localparam logic [31:0] F_NAN  = 32'h7FC0_0000;

    typedef struct {
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic [2:0]    cls;
        logic          err;
        logic [CW-1:0] cnt [5];
    } pixel_result_t;

    class pixel_scoreboard;
        pixel_result_t expected_q [$];
        logic [3:0]    kind;
        logic [2:0]    count;
        logic [CW-1:0] totals [5];
        int            errors;

        function new();
            kind   = KIND_DEPTH;
            count  = 3'd1;
            errors = 0;
            foreach (totals[i]) totals[i] = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            if (idx == REG_GUIDE_KIND) kind = data;
            else if (idx == REG_COMP_COUNT) count = data[2:0];
        endfunction

        function automatic void unpack(input logic [31:0] x, output logic [127:0] m,
                                       output int e);
            if (x[30:23] == 8'd0)
            begin
                m = {105'd0, x[22:0]};
                e = -149;
            end
            else
            begin
                m = {104'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        function automatic logic [31:0] pack_round(logic s, int e, logic [127:0] m);
            int           p;
            int           biased;
            int           sh;
            logic [127:0] q;
            logic [127:0] rem;
            logic [127:0] half;
            if (m == 0) return {s, 31'd0};
            p = 0;
            for (int i = 0; i < 128; i++) if (m[i]) p = i;
            biased = p + e + 127;
            sh = (biased >= 1) ? p - 23 : -149 - e;
            if (sh <= 0) q = m << (-sh);
            else if (sh > p + 1) q = 0;
            else
            begin
                q    = m >> sh;
                rem  = m & ((128'd1 << sh) - 128'd1);
                half = 128'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 1;
            end
            if (biased >= 1)
            begin
                if (q[24])
                begin
                    q      = q >> 1;
                    biased = biased + 1;
                end
                if (biased >= 255) return {s, 8'hFF, 23'd0};
                return {s, 8'(biased), q[22:0]};
            end
            return {s, q[30:0]};
        endfunction

        function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
            logic [127:0] ma;
            logic [127:0] mb;
            int           ea;
            int           eb;
            if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {a[31] ^ b[31], 8'hFF, 23'd0};
            unpack(a, ma, ea);
            unpack(b, mb, eb);
            return pack_round(a[31] ^ b[31], ea + eb, ma * mb);
        endfunction

        function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
            logic [31:0]  t;
            logic [127:0] ma;
            logic [127:0] mb;
            logic [127:0] m;
            int           ea;
            int           eb;
            int           e;
            int           d;
            logic         s;
            if (a[30:23] == 8'hFF) return a;
            if (b[30:23] == 8'hFF) return b;
            if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
            if (b[30:23] > a[30:23])
            begin
                t = a;
                a = b;
                b = t;
            end
            unpack(a, ma, ea);
            unpack(b, mb, eb);
            d = ea - eb;
            if (d > 50)
            begin
                ma = ma << 52;
                mb = (mb != 0) ? 128'd1 : 128'd0;
                e  = ea - 52;
            end
            else
            begin
                ma = ma << d;
                e  = eb;
            end
            if (a[31] == b[31])
            begin
                m = ma + mb;
                s = a[31];
            end
            else if (ma >= mb)
            begin
                m = ma - mb;
                s = a[31];
            end
            else
            begin
                m = mb - ma;
                s = b[31];
            end
            if (m == 0) return 32'd0;
            return pack_round(s, e, m);
        endfunction

        function automatic logic [31:0] order_key(logic [31:0] x);
            if (x[30:0] == 0) x = 32'd0;
            return x[31] ? ~x : (x | 32'h8000_0000);
        endfunction

        function automatic logic flt(logic [31:0] a, logic [31:0] b);
            return order_key(a) < order_key(b);
        endfunction

        function automatic logic [7:0] to_byte(logic [31:0] x);
            logic [31:0]  c;
            logic [127:0] m;
            int           e;
            if (flt(x, 32'd0)) c = 32'd0;
            else if (flt(F_ONE, x)) c = F_ONE;
            else c = x;
            c = fadd(fmul(c, F_255), F_HALF);
            unpack(c, m, e);
            m = (e >= 0) ? (m << e) : (m >> (-e));
            return m[7:0];
        endfunction

        function automatic void bump(int i);
            if (totals[i] != {CW{1'b1}}) totals[i] = totals[i] + 1'b1;
        endfunction

        function void note_pixel(logic first, logic [31:0] comp [4]);
            pixel_result_t r;
            logic [2:0]    want;
            logic          has_inf;
            logic          has_nan;
            logic          oor;
            logic [31:0]   s;
            logic [31:0]   rf;
            logic [31:0]   gf;
            logic [31:0]   bf;
            r.red = 0; r.green = 0; r.blue = 0; r.cls = CLS_VALID; r.err = 0;
            if (first) foreach (totals[i]) totals[i] = '0;
            if (kind <= KIND_HIT_DIST) want = 3'd1;
            else if (kind == KIND_MOTION) want = 3'd2;
            else if (kind <= KIND_SPEC_ALB) want = 3'd3;
            else if (kind == KIND_OVERLAY) want = 3'd4;
            else want = 3'd0;
            if (want == 0 || count != want) r.err = 1;
            else
            begin
                has_inf = 0;
                has_nan = 0;
                for (int i = 0; i < count; i++)
                begin
                    if (comp[i][30:23] == 8'hFF && comp[i][22:0] != 0) has_nan = 1;
                    if (comp[i][30:23] == 8'hFF && comp[i][22:0] == 0) has_inf = 1;
                end
                if (has_inf)
                begin
                    bump(2);
                    r.red = 255; r.green = 255; r.cls = CLS_INF;
                end
                else if (has_nan)
                begin
                    if (kind == KIND_DEPTH || kind == KIND_ROUGHNESS ||
                        kind == KIND_HIT_DIST || kind == KIND_NORMAL)
                    begin
                        bump(3);
                        r.cls = CLS_SENTINEL;
                    end
                    else
                    begin
                        bump(4);
                        r.cls = CLS_UNEXP_NAN;
                    end
                    r.red = 255; r.blue = 255;
                end
                else
                begin
                    oor = 0;
                    if (kind <= KIND_REACTIVE)
                        oor = flt(comp[0], 32'd0) || flt(F_ONE, comp[0]);
                    else if (kind == KIND_NORMAL)
                    begin
                        s = fmul(comp[0], comp[0]);
                        s = fadd(s, fmul(comp[1], comp[1]));
                        s = fadd(s, fmul(comp[2], comp[2]));
                        oor = flt(s, fmul(F_0P99, F_0P99)) || flt(fmul(F_1P01, F_1P01), s);
                    end
                    else if (kind >= KIND_DIFF_ALB)
                    begin
                        for (int i = 0; i < count; i++)
                            oor = oor || flt(comp[i], 32'd0) || flt(F_ONE, comp[i]);
                    end
                    else if (kind == KIND_HIT_DIST)
                        oor = flt(comp[0], 32'd0);
                    if (oor)
                    begin
                        bump(1);
                        r.cls = CLS_OOR;
                    end
                    bump(0);
                    rf = comp[0];
                    gf = (count > 1) ? comp[1] : rf;
                    bf = (count > 2) ? comp[2] : rf;
                    if (kind == KIND_NORMAL)
                    begin
                        rf = fadd(fmul(rf, F_HALF), F_HALF);
                        gf = fadd(fmul(gf, F_HALF), F_HALF);
                        bf = fadd(fmul(bf, F_HALF), F_HALF);
                    end
                    else if (kind == KIND_MOTION)
                    begin
                        rf = fadd(fmul(rf, F_EIGHT), F_HALF);
                        gf = fadd(fmul(gf, F_EIGHT), F_HALF);
                        bf = F_HALF;
                    end
                    r.red   = to_byte(rf);
                    r.green = to_byte(gf);
                    r.blue  = to_byte(bf);
                end
            end
            foreach (totals[i]) r.cnt[i] = totals[i];
            expected_q.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [DW-1:0] data, logic [3:0] user);
            pixel_result_t w;
            string         names [5] = '{"valid_count", "out_of_range_count",
                                         "infinite_count", "sentinel_count",
                                         "unexpected_nan_count"};
            if (expected_q.size() == 0)
            begin
                report("unexpected result", data[23:0], 0);
                return;
            end
            w = expected_q.pop_front();
            if (data[7:0] != w.red) report("red", data[7:0], w.red);
            if (data[15:8] != w.green) report("green", data[15:8], w.green);
            if (data[23:16] != w.blue) report("blue", data[23:16], w.blue);
            if (user[2:0] != w.cls) report("pixel_class", user[2:0], w.cls);
            if (user[3] != w.err) report("plane_error", user[3], w.err);
            for (int i = 0; i < 5; i++)
                if (data[24 + i*CW +: CW] != w.cnt[i])
                    report(names[i], data[24 + i*CW +: CW], w.cnt[i]);
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [3:0]        cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [127:0]      s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DW-1:0]     m_tdata;
    logic [3:0]        m_tuser;

    pixel_scoreboard   sb;
    int                cycles;
    bit                calm;
    int                sink_wait;

    guide_pixel_validator #(.COUNT_WIDTH(CW)) dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tuser);
                sink_wait = calm ? 0 : $urandom_range(0, 14);
                if (sink_wait > 0) m_tready <= 1'b0;
            end
            else if (!m_tready)
            begin
                if (sink_wait > 0) sink_wait--;
                if (sink_wait == 0) m_tready <= 1'b1;
            end
        end
    end

    task write_reg(logic [1:0] idx, logic [3:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task settle();
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task quiesce();
        s_tvalid <= 1'b0;
        settle();
    endtask

    task configure(logic [3:0] kind, logic [3:0] count);
        quiesce();
        write_reg(REG_GUIDE_KIND, kind);
        write_reg(REG_COMP_COUNT, count);
    endtask

    task send_pixel(logic first, logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                    logic [31:0] c3);
        logic [31:0] comp [4];
        int          gap;
        comp = '{c0, c1, c2, c3};
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {c3, c2, c1, c0};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pixel(first, comp);
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_comp(logic [3:0] kind);
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 15))
            0: x = F_INF | ({$urandom} << 31);
            1: x = {x[31], 8'hFF, x[22:1], 1'b1};
            2: x = {x[31], 31'd0};
            3: x = F_ONE;
            4, 5, 6, 7, 8: x = {1'b0, 8'($urandom_range(8'h70, 8'h7E)), x[22:0]};
            9: x = {x[31], 8'($urandom_range(8'h79, 8'h7E)), x[22:0]};
            10: x = {x[31], 8'd0, x[22:0]};
            11: x = {1'b0, 8'($urandom_range(8'h7F, 8'h86)), x[22:0]};
            default: ;
        endcase
        return x;
    endfunction

    task send_normal(logic first);
        logic [31:0] c [3];
        logic [31:0] pick;
        int          k;
        k = $urandom_range(0, 2);
        c = '{32'd0, 32'd0, 32'd0};
        case ($urandom_range(0, 2))
            0: c[k] = F_ONE | ({$urandom} << 31);
            1:
            begin
                c[k] = 32'h3F19_999A | ({$urandom} << 31);
                c[(k + 1) % 3] = 32'h3F4C_CCCD | ({$urandom} << 31);
            end
            default:
            begin
                pick = 32'h3F13_CD3A;
                c = '{pick | ({$urandom} << 31), pick | ({$urandom} << 31),
                      pick ^ $urandom_range(0, 1 << 18)};
            end
        endcase
        send_pixel(first, c[0], c[1], c[2], $urandom);
    endtask

    initial
    begin
        logic [3:0] kind;
        logic [3:0] cnt;
        logic [3:0] want;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b1;
        cycles    = 0;
        calm      = 0;
        sink_wait = 0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(1, 32'd0, 0, 0, 0);
        send_pixel(0, F_ONE, 0, 0, 0);
        send_pixel(0, 32'hBF80_0000, 0, 0, 0);
        send_pixel(0, F_NAN, 0, 0, 0);
        send_pixel(0, F_INF, 0, 0, 0);
        send_pixel(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        configure(KIND_NORMAL, 3);
        send_pixel(1, F_ONE, 0, 0, 0);
        send_pixel(0, 32'h3F19_999A, 32'hBF4C_CCCD, 0, 0);
        send_pixel(0, 32'h7F7F_FFFF, 0, 0, 0);
        send_pixel(0, 0, F_NAN, 0, 0);
        send_pixel(0, 0, F_NAN, 32'hFF80_0000, 0);
        configure(KIND_MOTION, 2);
        send_pixel(0, 32'h3E00_0000, 32'hBD80_0000, 0, 0);
        send_pixel(0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 0, 0);
        send_pixel(0, F_NAN, 0, 0, 0);
        configure(KIND_HIT_DIST, 1);
        send_pixel(0, 32'h8000_0000, 0, 0, 0);
        send_pixel(0, 32'hC000_0000, 0, 0, 0);
        configure(KIND_OVERLAY, 4);
        send_pixel(0, F_ONE, F_HALF, 0, 32'h3F80_0001);
        send_pixel(0, 0, 0, 0, F_NAN);
        configure(4'd15, 7);
        send_pixel(1, F_ONE, 0, 0, 0);
        quiesce();
        write_reg(REG_SPARE_A, 4'hF);
        write_reg(REG_SPARE_B, 4'h0);
        configure(KIND_DEPTH, 2);
        send_pixel(0, F_ONE, 0, 0, 0);

        for (int ph = 0; ph < 20; ph++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= KIND_HIT_DIST) want = 1;
            else if (kind == KIND_MOTION) want = 2;
            else if (kind <= KIND_SPEC_ALB) want = 3;
            else want = 4;
            cnt = want;
            if ($urandom_range(0, 5) == 0)
            begin
                kind = $urandom_range(0, 15);
                cnt  = $urandom_range(0, 15);
            end
            configure(kind, cnt);
            if ($urandom_range(0, 3) == 0)
                write_reg(2'($urandom_range(2, 3)), 4'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 40; i++)
            begin
                if (kind == KIND_NORMAL && $urandom_range(0, 1) == 0)
                    send_normal($urandom_range(0, 15) == 0);
                else
                    send_pixel($urandom_range(0, 15) == 0, rand_comp(kind),
                               rand_comp(kind), rand_comp(kind), rand_comp(kind));
            end
            calm = 0;
        end

        quiesce();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/gpv_pkg.sv
hdl/gpv_front.sv
hdl/gpv_queue.sv
hdl/gpv_back.sv
hdl/guide_pixel_validator.sv
test/guide_pixel_validator_tb.sv
